@@ rtl/core/glpf_pkg.sv @@
package glpf_pkg;

  // Field widths of the stream payloads
  localparam int SAMPLE_W = 32;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 5;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 6;
  localparam int OUT_DATA_W = 24;   // row + col, padded to whole bytes
  localparam int MAX_ROWS   = 4096;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_t;

  // Item sequencer, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RD0   = 7'b0000010,
    ST_RD1   = 7'b0000100,
    ST_RD2   = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_t;

endpackage

@@ rtl/core/glpf_ram.sv @@
module glpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/grid_local_peak_finder_unit.sv @@
// Channel  | Dir | Signals                                  | Item
// ---------+-----+------------------------------------------+------------------------------
// in_      | in  | in_tvalid, in_tready, in_tdata[31:0]     | one grid sample, raster order
// out_     | out | out_tvalid, out_tready, out_tdata, tlast | one peak (row, col)
// cfg_     | in  | cfg_we, cfg_index, cfg_wdata             | grid_rows / grid_cols write
//
// Each sample steps through accept, three reads of the row memories
// (left, center, right column), evaluate and write back, result slot.
// The single read port per row memory makes the three reads sequential.
// At the end of the last row, the bottom flags are scanned column by column.
// A result waits in the output register; the next sample is accepted meanwhile.
// rst_n is synchronous; the row memories and bottom flags need no clearing.
module grid_local_peak_finder_unit #(
  parameter int MAX_COLS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [glpf_pkg::SAMPLE_W-1:0]  in_tdata,    // [31:0] sample
  // peaks
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [glpf_pkg::OUT_DATA_W-1:0] out_tdata,  // [11:0] peak_row, [16:12] peak_col
  output logic                           out_tlast,
  // configuration
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [glpf_pkg::ROWS_CFG_W-1:0] cfg_wdata
);

  import glpf_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  // Configuration and control registers
  logic [ROWS_CFG_W-1:0] grid_rows_r;
  logic [COLS_CFG_W-1:0] grid_cols_r;
  state_t                state_r, state_nxt;
  logic [ROW_W-1:0]      row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]         col_cnt_r, col_cnt_nxt;
  logic                  bank_r, bank_nxt;
  logic [CW-1:0]         fi_r, fi_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Item payload registers
  logic signed [SAMPLE_W-1:0] v_r;
  logic [ROW_W-1:0]           ir_r;
  logic [CW-1:0]              ic_r;
  logic signed [SAMPLE_W-1:0] pl_r, ol_r, pc_r, oc_r;
  logic                       ok_r, flush_r;
  logic [MAX_COLS-1:0]        flags_r, flags_nxt;
  logic [ROW_W-1:0]           out_row_r, out_row_nxt;
  logic [CW-1:0]              out_col_r, out_col_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       load_out;

  // Effective geometry
  logic [ROW_W-1:0] rows_m1;
  logic [CW-1:0]    cols_m1;

  always_comb begin
    if (grid_rows_r == '0) begin
      rows_m1 = '0;
    end else if (grid_rows_r > ROWS_CFG_W'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(grid_rows_r - ROWS_CFG_W'(1));
    end
    if (grid_cols_r == '0) begin
      cols_m1 = '0;
    end else if (grid_cols_r > COLS_CFG_W'(MAX_COLS)) begin
      cols_m1 = CW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CW'(grid_cols_r - COLS_CFG_W'(1));
    end
  end

  // Position of an incoming sample, clamped to the current bounds
  logic [CW-1:0]    c_in;
  logic [ROW_W-1:0] r_in;
  assign c_in = (col_cnt_r > cols_m1) ? cols_m1 : col_cnt_r;
  assign r_in = (row_cnt_r > rows_m1) ? rows_m1 : row_cnt_r;

  // Neighbor presence for the item at work
  logic has_up, has_up2, has_left, has_right, is_last_row, is_row_end;
  assign has_up      = (ir_r != '0);
  assign has_up2     = (ir_r > ROW_W'(1));
  assign has_left    = (ic_r != '0);
  assign has_right   = (ic_r < cols_m1);
  assign is_last_row = (ir_r == rows_m1);
  assign is_row_end  = (ic_r == cols_m1);

  // Row memories: bank_r picks which one holds the prior row
  logic [CW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] rd0, rd1, prior_rd, older_rd;
  logic                       wr_en;

  always_comb begin
    case (1'b1)
      state_r[1]: rd_addr = has_left ? ic_r - CW'(1) : ic_r;   // RD0: left
      state_r[3]: rd_addr = has_right ? ic_r + CW'(1) : ic_r;  // RD2: right
      default:    rd_addr = ic_r;
    endcase
  end

  assign wr_en = (state_r == ST_EVAL);

  glpf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_ram0 (
    .clk   (clk),
    .we    (wr_en & bank_r),
    .waddr (ic_r),
    .wdata (v_r),
    .raddr (rd_addr),
    .rdata (rd0)
  );

  glpf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_ram1 (
    .clk   (clk),
    .we    (wr_en & ~bank_r),
    .waddr (ic_r),
    .wdata (v_r),
    .raddr (rd_addr),
    .rdata (rd1)
  );

  assign prior_rd = bank_r ? rd1 : rd0;
  assign older_rd = bank_r ? rd0 : rd1;

  // Peak test for the cell above, candidate flag for the bottom row
  logic ok_eval, f_eval;
  always_comb begin
    ok_eval = has_up && (pc_r >= v_r)
              && (!has_up2   || pc_r >= oc_r)
              && (!has_left  || pc_r >= pl_r)
              && (!has_right || pc_r >= prior_rd);
    f_eval  = (!has_up || v_r >= pc_r) && (!has_left || v_r >= ol_r);
    flags_nxt = flags_r;
    if (has_left && ol_r < v_r) begin
      flags_nxt[ic_r - CW'(1)] = 1'b0;
    end
    flags_nxt[ic_r] = f_eval;
  end

  // Column masks for the flush scan
  logic [MAX_COLS-1:0] col_mask, above_mask;
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i]   = (CW'(i) <= cols_m1);
      above_mask[i] = (CW'(i) > fi_r);
    end
  end

  logic any_flag, rest_flag, ofree;
  assign any_flag  = |(flags_r & col_mask);
  assign rest_flag = |(flags_r & col_mask & above_mask);
  assign ofree     = !out_valid_r || out_tready;

  // Sequencer and output register control
  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    bank_nxt      = bank_r;
    fi_nxt        = fi_r;
    out_valid_nxt = out_valid_r && !out_tready;
    load_out      = 1'b0;
    out_row_nxt   = ir_r;
    out_col_nxt   = ic_r;
    out_last_nxt  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: state_nxt = ST_RD1;
      ST_RD1: state_nxt = ST_RD2;
      ST_RD2: state_nxt = ST_EVAL;
      ST_EVAL: begin
        state_nxt = ST_EMIT;
        if (is_row_end) begin
          col_cnt_nxt = '0;
          bank_nxt    = ~bank_r;
          row_cnt_nxt = is_last_row ? '0 : ir_r + ROW_W'(1);
        end else begin
          col_cnt_nxt = ic_r + CW'(1);
          row_cnt_nxt = ir_r;
        end
      end
      ST_EMIT: begin
        out_row_nxt  = ir_r - ROW_W'(1);
        out_last_nxt = !(flush_r && any_flag);
        if (!ok_r || ofree) begin
          load_out  = ok_r;
          fi_nxt    = '0;
          state_nxt = flush_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        out_col_nxt  = fi_r;
        out_last_nxt = !rest_flag;
        if (!flags_r[fi_r] || ofree) begin
          load_out = flags_r[fi_r];
          if (fi_r == cols_m1) begin
            state_nxt = ST_IDLE;
          end else begin
            fi_nxt = fi_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      bank_r      <= 1'b0;
      fi_r        <= '0;
      out_valid_r <= 1'b0;
      grid_rows_r <= ROWS_CFG_W'(4);
      grid_cols_r <= COLS_CFG_W'(4);
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      bank_r      <= bank_nxt;
      fi_r        <= fi_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
          REG_GRID_COLS: grid_cols_r <= cfg_wdata[COLS_CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      v_r  <= in_tdata;
      ic_r <= c_in;
      ir_r <= r_in;
    end
    if (state_r == ST_RD1) begin
      pl_r <= prior_rd;
      ol_r <= older_rd;
    end
    if (state_r == ST_RD2) begin
      pc_r <= prior_rd;
      oc_r <= older_rd;
    end
    if (state_r == ST_EVAL) begin
      ok_r    <= ok_eval;
      flush_r <= is_last_row && is_row_end;
      if (is_last_row) begin
        flags_r <= flags_nxt;
      end
    end
    if (load_out) begin
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ROW_W - COL_W){1'b0}}, COL_W'(out_col_r), out_row_r};
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/glpf_checker.sv @@
module glpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled peak holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled peak changed");

  // One sample at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample accepted while busy");

  // Padding above the column field stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0)
    else $error("nonzero padding in peak data");

endmodule

bind grid_local_peak_finder_unit glpf_checker u_glpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
